[rtl/eased_camera_move_sequencer_core_assert.svh]
// ----------------------------------------------------------------------------
// eased camera move sequencer assertion macros
// concurrent checks, empty when synthesizing
// ----------------------------------------------------------------------------
`ifndef EASED_CAMERA_MOVE_SEQUENCER_CORE_ASSERT_SVH
`define EASED_CAMERA_MOVE_SEQUENCER_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check outside reset
`define ECMS_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("ecms assertion failed");
// check that also spans reset
`define ECMS_ASSERT_RST(label, prop) \
    label: assert property (@(posedge i_clk) prop) \
        else $error("ecms reset assertion failed");
`else
`define ECMS_ASSERT(label, prop)
`define ECMS_ASSERT_RST(label, prop)
`endif

`endif

[rtl/ecms_pkg.sv]
// ----------------------------------------------------------------------------
// ecms_pkg
// codes and widths shared by the eased camera move sequencer
// ----------------------------------------------------------------------------
`default_nettype none

package ecms_pkg;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_PAN    = 2'd1;
    localparam logic [1:0] PH_HOLD   = 2'd2;
    localparam logic [1:0] PH_RETURN = 2'd3;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_TRIGGER = 2'd1;
    localparam logic [1:0] OP_SKIP    = 2'd2;

    localparam logic [2:0] CFG_PAN_TIME    = 3'd0;
    localparam logic [2:0] CFG_HOLD_TIME   = 3'd1;
    localparam logic [2:0] CFG_RETURN_TIME = 3'd2;
    localparam logic [2:0] CFG_DEST_HEIGHT = 3'd3;
    localparam logic [2:0] CFG_DEST_ZOOM   = 3'd4;

    // snapshot slots
    localparam logic [2:0] SL_X = 3'd0;
    localparam logic [2:0] SL_Y = 3'd1;
    localparam logic [2:0] SL_Z = 3'd2;
    localparam logic [2:0] SL_D = 3'd3;
    localparam logic [2:0] SL_A = 3'd4;

    localparam int SLOTS    = 5;
    localparam int FRAC_W   = 16;
    localparam int IN_W     = 248;
    localparam int OUT_W    = 168;

    typedef logic signed [31:0] t_q16;

endpackage

`default_nettype wire

[rtl/eased_camera_move_sequencer_core.sv]
// ----------------------------------------------------------------------------
// eased camera move sequencer core
// pan, hold and return moves of a camera target with smoothstep easing
// ----------------------------------------------------------------------------
//  channel   dir  signals                                  word
//  s_axis    in   tvalid tready tuser[1:0] tdata[247:0]    command / tick
//  m_axis    out  tvalid tready tdata[167:0]               camera state
//  cfg       in   we idx[2:0] data[31:0]                   register write
//
//  trigger, skip, hold and phase-end ticks go from entry straight to the output
//  load; easing ticks pass the bit-serial divider producing the ease fraction,
//  the smoothstep multiplies and the shared blend multiplier (one snapshot
//  slot a cycle) before the output load
//  one item at a time; a finished word waits in the output register while
//  the next item is accepted; reset is synchronous, active low, no sweep
// ----------------------------------------------------------------------------
`default_nettype none

`include "eased_camera_move_sequencer_core_assert.svh"

module eased_camera_move_sequencer_core (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // opcode
    input  wire logic [1:0]   s_axis_tuser,
    // delta_us, dest_x, dest_z, cam_x, cam_y, cam_z, cam_distance,
    // cam_angle, zero pad
    input  wire logic [247:0] s_axis_tdata,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    // phase_code, active, out_x, out_y, out_z, out_distance, out_angle,
    // zero pad
    output logic [167:0]      m_axis_tdata,
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    input  wire logic         i_cfg_we,
    input  wire logic [2:0]   i_cfg_idx,
    input  wire logic [31:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV,
        ST_SQ,
        ST_POLY,
        ST_BLEND,
        ST_DONE
    } t_state;

    t_state r_state;

    logic [23:0] r_pan_time;
    logic [23:0] r_hold_time;
    logic [23:0] r_return_time;
    logic [31:0] r_dest_height;
    logic [30:0] r_dest_zoom;

    logic [1:0]  r_phase;
    logic [24:0] r_elapsed;
    ecms_pkg::t_q16 r_origin [ecms_pkg::SLOTS];
    ecms_pkg::t_q16 r_dest   [ecms_pkg::SLOTS];
    ecms_pkg::t_q16 r_cur    [ecms_pkg::SLOTS];

    logic [24:0] r_rem;
    logic [23:0] r_dur;
    logic [15:0] r_q;
    logic [3:0]  r_cnt;
    logic        r_fwd;
    logic [31:0] r_tt;
    logic [16:0] r_s;
    logic [2:0]  r_idx;

    logic         r_ovalid;
    logic [161:0] r_odata;

    // input fields
    logic [1:0]  w_op;
    logic [19:0] w_delta;
    logic [31:0] w_dest_x, w_dest_z, w_cam_x, w_cam_y, w_cam_z, w_cam_angle;
    logic [30:0] w_cam_dist;

    assign w_op        = s_axis_tuser;
    assign w_delta     = s_axis_tdata[19:0];
    assign w_dest_x    = s_axis_tdata[51:20];
    assign w_dest_z    = s_axis_tdata[83:52];
    assign w_cam_x     = s_axis_tdata[115:84];
    assign w_cam_y     = s_axis_tdata[147:116];
    assign w_cam_z     = s_axis_tdata[179:148];
    assign w_cam_dist  = s_axis_tdata[210:180];
    assign w_cam_angle = s_axis_tdata[242:211];

    logic [24:0] w_el_sum;
    logic [23:0] w_dur;
    logic        w_el_ge;
    logic        w_ease;

    assign w_el_sum = r_elapsed + 25'(w_delta);
    always_comb begin
        case (r_phase)
            ecms_pkg::PH_PAN:  w_dur = r_pan_time;
            ecms_pkg::PH_HOLD: w_dur = r_hold_time;
            default:           w_dur = r_return_time;
        endcase
    end
    assign w_el_ge = (w_el_sum >= {1'b0, w_dur});

    // tick inside a pan or return that does not end it needs the easing path
    assign w_ease = (w_op == ecms_pkg::OP_TICK) &&
                    ((r_phase == ecms_pkg::PH_PAN) || (r_phase == ecms_pkg::PH_RETURN)) &&
                    !w_el_ge;

    // divider step: one quotient bit a cycle
    logic [24:0] w_sh;
    logic        w_sub;
    assign w_sh  = {r_rem[23:0], 1'b0};
    assign w_sub = (w_sh >= {1'b0, r_dur});

    // smoothstep polynomial
    logic [17:0] w_k;
    logic [49:0] w_poly;
    assign w_k    = 18'd196608 - {1'b0, r_q, 1'b0};
    assign w_poly = r_tt * w_k + 50'h0_8000_0000;

    // blend of one slot
    ecms_pkg::t_q16     w_a, w_b;
    logic signed [32:0] w_diff;
    logic signed [49:0] w_prod;
    assign w_a    = r_fwd ? r_origin[r_idx] : r_dest[r_idx];
    assign w_b    = r_fwd ? r_dest[r_idx] : r_origin[r_idx];
    assign w_diff = {w_b[31], w_b} - {w_a[31], w_a};
    assign w_prod = w_diff * $signed({1'b0, r_s}) + 50'sd32768;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = {6'b0, r_odata};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_pan_time    <= 24'd500000;
            r_hold_time   <= 24'd1000000;
            r_return_time <= 24'd500000;
            r_dest_height <= '0;
            r_dest_zoom   <= 31'd655360;
            r_phase       <= ecms_pkg::PH_IDLE;
            r_elapsed     <= '0;
            for (int i = 0; i < ecms_pkg::SLOTS; i++) begin
                r_origin[i] <= '0;
                r_dest[i]   <= '0;
                r_cur[i]    <= '0;
            end
            r_ovalid      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    ecms_pkg::CFG_PAN_TIME:    r_pan_time    <= i_cfg_data[23:0];
                    ecms_pkg::CFG_HOLD_TIME:   r_hold_time   <= i_cfg_data[23:0];
                    ecms_pkg::CFG_RETURN_TIME: r_return_time <= i_cfg_data[23:0];
                    ecms_pkg::CFG_DEST_HEIGHT: r_dest_height <= i_cfg_data;
                    ecms_pkg::CFG_DEST_ZOOM:   r_dest_zoom   <= i_cfg_data[30:0];
                    default: ;
                endcase
            end
            if (m_axis_tready && (r_state != ST_DONE)) begin
                r_ovalid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: if (s_axis_tvalid) begin
                    r_state <= w_ease ? ST_DIV : ST_DONE;
                    case (w_op)
                        ecms_pkg::OP_TICK: if (r_phase != ecms_pkg::PH_IDLE) begin
                            if (r_phase == ecms_pkg::PH_HOLD) begin
                                r_cur <= r_dest;
                                if (w_el_ge) begin
                                    r_phase   <= ecms_pkg::PH_RETURN;
                                    r_elapsed <= '0;
                                end else begin
                                    r_elapsed <= w_el_sum;
                                end
                            end else if (w_el_ge) begin
                                // phase end, overshoot dropped
                                r_elapsed <= '0;
                                if (r_phase == ecms_pkg::PH_PAN) begin
                                    r_cur   <= r_dest;
                                    r_phase <= ecms_pkg::PH_HOLD;
                                end else begin
                                    r_cur   <= r_origin;
                                    r_phase <= ecms_pkg::PH_IDLE;
                                end
                            end else begin
                                r_elapsed <= w_el_sum;
                                r_rem     <= {1'b0, w_el_sum[23:0]};
                                r_dur     <= w_dur;
                                r_cnt     <= '0;
                                r_fwd     <= (r_phase == ecms_pkg::PH_PAN);
                            end
                        end
                        ecms_pkg::OP_TRIGGER: begin
                            r_origin[ecms_pkg::SL_X] <= w_cam_x;
                            r_origin[ecms_pkg::SL_Y] <= w_cam_y;
                            r_origin[ecms_pkg::SL_Z] <= w_cam_z;
                            r_origin[ecms_pkg::SL_D] <= {1'b0, w_cam_dist};
                            r_origin[ecms_pkg::SL_A] <= w_cam_angle;
                            r_cur[ecms_pkg::SL_X]    <= w_cam_x;
                            r_cur[ecms_pkg::SL_Y]    <= w_cam_y;
                            r_cur[ecms_pkg::SL_Z]    <= w_cam_z;
                            r_cur[ecms_pkg::SL_D]    <= {1'b0, w_cam_dist};
                            r_cur[ecms_pkg::SL_A]    <= w_cam_angle;
                            r_dest[ecms_pkg::SL_X]   <= w_dest_x;
                            r_dest[ecms_pkg::SL_Y]   <= r_dest_height;
                            r_dest[ecms_pkg::SL_Z]   <= w_dest_z;
                            r_dest[ecms_pkg::SL_D]   <= {1'b0, r_dest_zoom};
                            r_dest[ecms_pkg::SL_A]   <= w_cam_angle;
                            r_phase                  <= ecms_pkg::PH_PAN;
                            r_elapsed                <= '0;
                        end
                        ecms_pkg::OP_SKIP: if (r_phase != ecms_pkg::PH_IDLE) begin
                            r_cur     <= r_origin;
                            r_phase   <= ecms_pkg::PH_IDLE;
                            r_elapsed <= '0;
                        end
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    r_rem <= w_sub ? (w_sh - {1'b0, r_dur}) : w_sh;
                    r_q   <= {r_q[14:0], w_sub};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt == 4'd15) begin
                        r_state <= ST_SQ;
                    end
                end
                ST_SQ: begin
                    r_tt    <= r_q * r_q;
                    r_state <= ST_POLY;
                end
                ST_POLY: begin
                    r_s     <= w_poly[48:32];
                    r_idx   <= ecms_pkg::SL_X;
                    r_state <= ST_BLEND;
                end
                ST_BLEND: begin
                    r_cur[r_idx] <= w_a + w_prod[47:16];
                    r_idx        <= r_idx + 3'd1;
                    if (r_idx == ecms_pkg::SL_A) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: if (!r_ovalid || m_axis_tready) begin
                    r_odata  <= {r_cur[ecms_pkg::SL_A], r_cur[ecms_pkg::SL_D][30:0],
                                 r_cur[ecms_pkg::SL_Z], r_cur[ecms_pkg::SL_Y],
                                 r_cur[ecms_pkg::SL_X],
                                 (r_phase != ecms_pkg::PH_IDLE), r_phase};
                    r_ovalid <= 1'b1;
                    r_state  <= ST_IDLE;
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `ECMS_ASSERT(a_active_matches_phase,
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] != ecms_pkg::PH_IDLE)))
    `ECMS_ASSERT(a_rem_below_dur, (r_state == ST_DIV) |-> (r_rem < {1'b0, r_dur}))
    `ECMS_ASSERT(a_blend_slot_range, (r_state == ST_BLEND) |-> (r_idx <= ecms_pkg::SL_A))
    `ECMS_ASSERT_RST(a_reset_clears_out, !i_rst_n |=> !m_axis_tvalid)

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// ----------------------------------------------------------------------------
// eased camera move sequencer testbench
// drives command and tick words into the core, predicts every camera state
// word in fixed point and compares it field by field; directed table first,
// then random move sequences under several register settings
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

    localparam int LIMIT_CYCLES = 2000000;
    localparam logic [1:0] OP_SPARE = 2'd3;
    localparam logic [2:0] CFG_NONE = 3'd7;

    typedef struct packed {
        logic [31:0] ang;
        logic [30:0] dist_q;
        logic [31:0] z;
        logic [31:0] y;
        logic [31:0] x;
        logic        act;
        logic [1:0]  phase;
    } t_cam;

    typedef struct {
        logic [1:0]  op;
        logic [19:0] delta;
        logic [31:0] dx;
        logic [31:0] dz;
        logic [31:0] cx;
        logic [31:0] cy;
        logic [31:0] cz;
        logic [30:0] cd;
        logic [31:0] ca;
        bit          fixed;
        logic [1:0]  exp_phase;
    } t_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic [1:0]   s_axis_tuser = '0;
    logic [247:0] s_axis_tdata = '0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [167:0] m_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic         i_cfg_we = 1'b0;
    logic [2:0]   i_cfg_idx = '0;
    logic [31:0]  i_cfg_data = '0;

    eased_camera_move_sequencer_core i_dut (.*);

    always #4 i_clk = ~i_clk;

    // predictor state
    logic [23:0]   pan_us, hold_us, ret_us;
    longint        height_q, zoom_q;
    logic [1:0]    cam_phase;
    logic [24:0]   elapsed;
    longint        orig[5], dst[5], cur[5];

    t_cam          cam_queue[$];
    logic [1:0]    phase_queue[$];
    bit            phase_known[$];
    int            errors = 0;
    int            cycles = 0;
    int            stall_left = 0;
    bit            quiet = 1'b0;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        errors++;
    endtask

    function automatic longint sx32(logic [31:0] v);
        return longint'(signed'(v));
    endfunction

    function automatic longint ease_mix(longint a, longint b, logic [24:0] el, logic [23:0] dur);
        longint unsigned t, tt, k, s;
        longint prod;
        if (el >= dur) t = 65536;
        else t = (longint'(el) << 16) / dur;
        tt = t * t;
        k = 196608 - 2 * t;
        s = (tt * k + 64'h8000_0000) >> 32;
        prod = (b - a) * longint'(s) + 32768;
        return a + (prod >>> 16);
    endfunction

    task automatic blend_all(input bit to_dst, input logic [23:0] dur);
        for (int i = 0; i < 5; i++)
            cur[i] = to_dst ? ease_mix(orig[i], dst[i], elapsed, dur)
                            : ease_mix(dst[i], orig[i], elapsed, dur);
    endtask

    task automatic predict_camera(input t_row r, output t_cam c);
        if (r.op == ecms_pkg::OP_TICK) begin
            if (cam_phase != ecms_pkg::PH_IDLE) begin
                elapsed = elapsed + 25'(r.delta);
                case (cam_phase)
                    ecms_pkg::PH_PAN: begin
                        blend_all(1'b1, pan_us);
                        if (elapsed >= pan_us) begin
                            cur = dst; cam_phase = ecms_pkg::PH_HOLD; elapsed = '0;
                        end
                    end
                    ecms_pkg::PH_HOLD: begin
                        cur = dst;
                        if (elapsed >= hold_us) begin
                            cam_phase = ecms_pkg::PH_RETURN; elapsed = '0;
                        end
                    end
                    default: begin
                        blend_all(1'b0, ret_us);
                        if (elapsed >= ret_us) begin
                            cur = orig; cam_phase = ecms_pkg::PH_IDLE; elapsed = '0;
                        end
                    end
                endcase
            end
        end else if (r.op == ecms_pkg::OP_TRIGGER) begin
            orig[0] = sx32(r.cx); orig[1] = sx32(r.cy); orig[2] = sx32(r.cz);
            orig[3] = longint'(r.cd); orig[4] = sx32(r.ca);
            dst[0] = sx32(r.dx); dst[1] = height_q; dst[2] = sx32(r.dz);
            dst[3] = zoom_q; dst[4] = orig[4];
            cur = orig; cam_phase = ecms_pkg::PH_PAN; elapsed = '0;
        end else if (r.op == ecms_pkg::OP_SKIP) begin
            if (cam_phase != ecms_pkg::PH_IDLE) begin
                cur = orig; cam_phase = ecms_pkg::PH_IDLE; elapsed = '0;
            end
        end
        c.phase = cam_phase;
        c.act = cam_phase != ecms_pkg::PH_IDLE;
        c.x = cur[0][31:0]; c.y = cur[1][31:0]; c.z = cur[2][31:0];
        c.dist_q = cur[3][30:0]; c.ang = cur[4][31:0];
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            ecms_pkg::CFG_PAN_TIME:    pan_us = val[23:0];
            ecms_pkg::CFG_HOLD_TIME:   hold_us = val[23:0];
            ecms_pkg::CFG_RETURN_TIME: ret_us = val[23:0];
            ecms_pkg::CFG_DEST_HEIGHT: height_q = sx32(val);
            ecms_pkg::CFG_DEST_ZOOM:   zoom_q = longint'(val[30:0]);
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (cam_queue.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // valid stays high after a word, but for random gaps outside the quiet stretch; callers drop it when done
    task automatic send_word(input t_row r);
        t_cam c;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        predict_camera(r, c);
        cam_queue.push_back(c);
        phase_queue.push_back(r.exp_phase);
        phase_known.push_back(r.fixed);
        s_axis_tuser <= r.op;
        s_axis_tdata <= {5'd0, r.ca, r.cd, r.cz, r.cy, r.cx, r.dz, r.dx, r.delta};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    function automatic t_row mk(logic [1:0] op, logic [19:0] d);
        t_row r;
        r.op = op; r.delta = d;
        r.dx = $urandom; r.dz = $urandom; r.cx = $urandom; r.cy = $urandom;
        r.cz = $urandom; r.cd = 31'($urandom); r.ca = $urandom;
        r.fixed = 1'b0; r.exp_phase = ecms_pkg::PH_IDLE;
        return r;
    endfunction

    function automatic t_row mkf(logic [1:0] op, logic [19:0] d, logic [1:0] ph);
        t_row r = mk(op, d);
        r.fixed = 1'b1; r.exp_phase = ph;
        return r;
    endfunction

    // result side: random stall bursts, checks against the oldest expectation
    always @(posedge i_clk) begin
        t_cam got, want;
        cycles <= cycles + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[161:0];
            if (cam_queue.size() == 0) begin
                report_mismatch("unexpected word", longint'(got.phase), -1);
            end else begin
                want = cam_queue.pop_front();
                if (phase_known.pop_front() && phase_queue[0] != got.phase)
                    report_mismatch("table phase", got.phase, phase_queue[0]);
                void'(phase_queue.pop_front());
                if (got.phase !== want.phase) report_mismatch("phase", got.phase, want.phase);
                if (got.act !== want.act) report_mismatch("active", got.act, want.act);
                if (got.x !== want.x) report_mismatch("x", got.x, want.x);
                if (got.y !== want.y) report_mismatch("y", got.y, want.y);
                if (got.z !== want.z) report_mismatch("z", got.z, want.z);
                if (got.dist_q !== want.dist_q)
                    report_mismatch("distance", got.dist_q, want.dist_q);
                if (got.ang !== want.ang) report_mismatch("angle", got.ang, want.ang);
            end
            if (m_axis_tdata[167:162] !== 6'd0)
                report_mismatch("pad", longint'(m_axis_tdata[167:162]), 0);
        end
        if (quiet) begin
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 7) == 0) begin
            stall_left <= int'($urandom_range(0, 9));
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (cycles >= LIMIT_CYCLES) begin
            $display("timeout");
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic random_phase(input int n);
        t_row r;
        int pick;
        for (int i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 8) r = mk(ecms_pkg::OP_TRIGGER, 20'($urandom));
            else if (pick < 11) r = mk(ecms_pkg::OP_SKIP, 20'($urandom));
            else if (pick < 13) r = mk(OP_SPARE, 20'($urandom));
            else if (pick < 17) r = mk(ecms_pkg::OP_TICK, 20'($urandom_range(999000, 1000000)));
            else if (pick < 22) r = mk(ecms_pkg::OP_TICK, 20'($urandom));
            else r = mk(ecms_pkg::OP_TICK, 20'($urandom_range(0, 2 * int'(pan_us) / 5 + 1)));
            if (r.op == ecms_pkg::OP_TICK && r.delta > 1000000) r.delta = 1000000;
            send_word(r);
        end
    endtask

    initial begin
        t_row tbl[$];
        t_row r;
        pan_us = 24'd500000; hold_us = 24'd1000000; ret_us = 24'd500000;
        height_q = 0; zoom_q = 655360;
        cam_phase = ecms_pkg::PH_IDLE; elapsed = '0;
        foreach (orig[i]) begin orig[i] = 0; dst[i] = 0; cur[i] = 0; end
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // tick and skip while idle, unused opcode, trigger, extremes of delta
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd1000000, ecms_pkg::PH_IDLE));
        tbl.push_back(mkf(ecms_pkg::OP_SKIP, 20'd0, ecms_pkg::PH_IDLE));
        tbl.push_back(mkf(OP_SPARE, 20'hFFFFF, ecms_pkg::PH_IDLE));
        r = mkf(ecms_pkg::OP_TRIGGER, 20'd0, ecms_pkg::PH_PAN);
        r.cx = 32'h8000_0000; r.cy = 32'h7FFF_FFFF; r.cz = 32'h0; r.cd = 31'h7FFF_FFFF;
        r.ca = 32'h8000_0000; r.dx = 32'h7FFF_FFFF; r.dz = 32'h8000_0000;
        tbl.push_back(r);
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd0));
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd1));
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd250000));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd1000000, ecms_pkg::PH_HOLD));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd999999, ecms_pkg::PH_HOLD));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd1, ecms_pkg::PH_RETURN));
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd123457));
        tbl.push_back(mk(OP_SPARE, 20'd5));
        tbl.push_back(mkf(ecms_pkg::OP_TRIGGER, 20'd0, ecms_pkg::PH_PAN));
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd499999));
        tbl.push_back(mkf(ecms_pkg::OP_TRIGGER, 20'hFFFFF, ecms_pkg::PH_PAN));
        tbl.push_back(mkf(ecms_pkg::OP_SKIP, 20'd0, ecms_pkg::PH_IDLE));
        tbl.push_back(mkf(ecms_pkg::OP_TRIGGER, 20'd0, ecms_pkg::PH_PAN));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd500000, ecms_pkg::PH_HOLD));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd1000000, ecms_pkg::PH_RETURN));
        tbl.push_back(mk(ecms_pkg::OP_TICK, 20'd300000));
        tbl.push_back(mkf(ecms_pkg::OP_TICK, 20'd200000, ecms_pkg::PH_IDLE));
        foreach (tbl[i]) send_word(tbl[i]);
        wait_drained();

        // extremes of every register, then random settings
        write_reg(ecms_pkg::CFG_PAN_TIME, 32'h00FF_FFFF);
        write_reg(ecms_pkg::CFG_HOLD_TIME, 32'd1);
        write_reg(ecms_pkg::CFG_RETURN_TIME, 32'hFFFF_FFFF);
        write_reg(ecms_pkg::CFG_DEST_HEIGHT, 32'h8000_0000);
        write_reg(ecms_pkg::CFG_DEST_ZOOM, 32'hFFFF_FFFF);
        write_reg(CFG_NONE, 32'h1234_5678);
        random_phase(120);
        wait_drained();

        write_reg(ecms_pkg::CFG_PAN_TIME, 32'd1);
        write_reg(ecms_pkg::CFG_HOLD_TIME, 32'h00FF_FFFF);
        write_reg(ecms_pkg::CFG_RETURN_TIME, 32'd1);
        write_reg(ecms_pkg::CFG_DEST_HEIGHT, 32'h7FFF_FFFF);
        write_reg(ecms_pkg::CFG_DEST_ZOOM, 32'd0);
        random_phase(80);
        wait_drained();

        for (int k = 0; k < 3; k++) begin
            write_reg(ecms_pkg::CFG_PAN_TIME, $urandom_range(1, 3000000));
            write_reg(ecms_pkg::CFG_HOLD_TIME, $urandom_range(1, 2000000));
            write_reg(ecms_pkg::CFG_RETURN_TIME, $urandom_range(1, 3000000));
            write_reg(ecms_pkg::CFG_DEST_HEIGHT, $urandom);
            write_reg(ecms_pkg::CFG_DEST_ZOOM, $urandom);
            random_phase(k == 2 ? 100 : 150);
            wait_drained();
        end

        // closing stretch without idling
        quiet = 1'b1;
        random_phase(40);
        wait_drained();

        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[eased_camera_move_sequencer_core.f]
+incdir+rtl
rtl/ecms_pkg.sv
rtl/eased_camera_move_sequencer_core.sv
tb/sv/testbench.sv
